[rtl/qrdm_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and mod-3 helpers for the qutrit repetition defect block
package qrdm_pkg;

  localparam int DIST_W     = 9;
  localparam int COUNT_W    = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic CMD_SYNDROME = 1'b0;
  localparam logic CMD_DATA     = 1'b1;

  localparam logic [1:0] KIND_ROUND    = 2'd0;
  localparam logic [1:0] KIND_BOUNDARY = 2'd1;
  localparam logic [1:0] KIND_DECISION = 2'd2;

  typedef enum logic [1:0] {
    REG_DISTANCE = 2'd0,
    REG_ROUNDS   = 2'd1,
    REG_EMIT_ALL = 2'd2,
    REG_EXPECTED = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] code_distance;
    logic [9:0] round_count;
    logic       emit_all;
    logic [1:0] expected_logical;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [5:0]        position;
    logic [9:0]        round_number;
    logic signed [7:0] raw_value;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] round_label;
    logic [5:0] edge_index;
    logic [1:0] syndrome_value;
    logic [1:0] previous_value;
    logic [1:0] defect_value;
    logic [1:0] decision;
    logic       tie;
    logic       failure;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  // residue mod 3 by folding base-4 digits
  function automatic logic [1:0] mod3_9(input logic [8:0] x);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] s3;
    s1 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[8]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    s3 = s2[1:0] + 2'(s2[2]);
    return (s3 == 2'd3) ? 2'd0 : s3;
  endfunction

  // a minus b mod 3, both in 0..2
  function automatic logic [1:0] sub3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] t;
    t = {1'b0, a} + 3'd3 - {1'b0, b};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

[rtl/qrdm_ram.sv]
`timescale 1ns / 1ps
// generic single-port-write ram with registered read
module qrdm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 63
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/qrdm_cfg.sv]
`timescale 1ns / 1ps
// apb configuration registers
module qrdm_cfg import qrdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_distance    <= 7'd3;
      cfg_r.round_count      <= 10'd5;
      cfg_r.emit_all         <= 1'b0;
      cfg_r.expected_logical <= 2'd0;
    end else if (wr) begin
      case (idx)
        REG_DISTANCE: cfg_r.code_distance    <= pwdata[6:0];
        REG_ROUNDS:   cfg_r.round_count      <= pwdata[9:0];
        REG_EMIT_ALL: cfg_r.emit_all         <= pwdata[0];
        REG_EXPECTED: cfg_r.expected_logical <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DISTANCE: prdata = 32'(cfg_r.code_distance);
      REG_ROUNDS:   prdata = 32'(cfg_r.round_count);
      REG_EMIT_ALL: prdata = 32'(cfg_r.emit_all);
      REG_EXPECTED: prdata = 32'(cfg_r.expected_logical);
      default:      prdata = 32'd0;
    endcase
  end

endmodule

[rtl/qrdm_core.sv]
`timescale 1ns / 1ps
// input register, syndrome store and single-pass defect and majority logic
module qrdm_core import qrdm_pkg::*; #(
  parameter int MAX_DISTANCE = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  room,
  output push_t push
);

  localparam int EDGES = MAX_DISTANCE - 1;
  localparam int AW    = (EDGES > 1) ? $clog2(EDGES) : 1;

  logic               s1_valid_r;
  item_t              s1_item_r;
  logic               byp_hit_r;
  logic [1:0]         byp_data_r;
  logic [1:0]         last_data_r;
  logic [COUNT_W-1:0] cnt_r   [3];
  logic [COUNT_W-1:0] cnt_nxt [3];
  logic [EDGES-1:0]   vld_r;

  logic               advance, accept;
  logic [5:0]         rd_pos, s1_pos;
  logic [AW-1:0]      raddr, s1_addr;
  logic [1:0]         rdata;
  logic               we;

  logic [1:0]         val, stored_prev, prev, check, def;
  logic [DIST_W-1:0]  d_sat, pos9;
  logic               syn_ok, data_ok, is_last, ea, eb;
  logic [1:0]         best;
  logic [COUNT_W-1:0] best_cnt;
  logic               tied;
  logic [1:0]         dec;
  result_t            res_a, res_b;

  assign advance  = s1_valid_r & room;
  assign in_ready = ~s1_valid_r | room;
  assign accept   = in_valid & in_ready;

  assign rd_pos  = (in_item.cmd == CMD_DATA) ? in_item.position - 6'd1 : in_item.position;
  assign raddr   = AW'(rd_pos);
  assign s1_pos  = (s1_item_r.cmd == CMD_DATA) ? s1_item_r.position - 6'd1
                                               : s1_item_r.position;
  assign s1_addr = AW'(s1_pos);

  qrdm_ram #(
    .WIDTH (2),
    .DEPTH (EDGES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (val),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    d_sat = DIST_W'(cfg.code_distance);
    if (d_sat < DIST_W'(2)) begin
      d_sat = DIST_W'(2);
    end else if (d_sat > DIST_W'(MAX_DISTANCE)) begin
      d_sat = DIST_W'(MAX_DISTANCE);
    end
  end

  assign pos9 = DIST_W'(s1_item_r.position);
  assign val  = mod3_9(s1_item_r.raw_value[7] ? {1'b0, s1_item_r.raw_value} + 9'd2
                                              : {1'b0, s1_item_r.raw_value});

  assign syn_ok  = (s1_item_r.cmd == CMD_SYNDROME) && (pos9 + DIST_W'(1) < d_sat);
  assign data_ok = (s1_item_r.cmd == CMD_DATA) && (pos9 < d_sat);
  assign is_last = data_ok && (pos9 + DIST_W'(1) == d_sat);
  assign we      = advance & syn_ok;

  assign stored_prev = byp_hit_r ? byp_data_r : (vld_r[s1_addr] ? rdata : 2'd0);
  assign check       = sub3(last_data_r, val);
  assign prev        = (syn_ok && s1_item_r.round_number == 10'd0) ? 2'd0 : stored_prev;
  assign def         = syn_ok ? sub3(val, prev) : sub3(check, prev);

  assign ea = (syn_ok || (data_ok && s1_item_r.position != 6'd0)) &&
              (cfg.emit_all || def != 2'd0);
  assign eb = is_last;

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      cnt_nxt[s] = (s1_item_r.position == 6'd0) ? '0 : cnt_r[s];
      if (val == 2'(s) && cnt_nxt[s] < COUNT_MAX) begin
        cnt_nxt[s] = cnt_nxt[s] + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    best     = 2'd0;
    best_cnt = cnt_nxt[0];
    tied     = 1'b0;
    if (cnt_nxt[1] > best_cnt) begin
      best     = 2'd1;
      best_cnt = cnt_nxt[1];
    end else if (cnt_nxt[1] == best_cnt) begin
      tied = 1'b1;
    end
    if (cnt_nxt[2] > best_cnt) begin
      best = 2'd2;
      tied = 1'b0;
    end else if (cnt_nxt[2] == best_cnt) begin
      tied = 1'b1;
    end
  end

  assign dec = tied ? 2'd0 : best;

  always_comb begin
    res_a                = '0;
    res_a.kind           = syn_ok ? KIND_ROUND : KIND_BOUNDARY;
    res_a.round_label    = syn_ok ? s1_item_r.round_number : cfg.round_count;
    res_a.edge_index     = s1_pos;
    res_a.syndrome_value = syn_ok ? val : check;
    res_a.previous_value = prev;
    res_a.defect_value   = def;
    res_a.last           = ~eb;

    res_b             = '0;
    res_b.kind        = KIND_DECISION;
    res_b.round_label = cfg.round_count;
    res_b.decision    = dec;
    res_b.tie         = tied;
    res_b.failure     = tied || ({1'b0, dec} != {1'b0, cfg.expected_logical});
    res_b.last        = 1'b1;
  end

  assign push.v0 = advance & (ea | eb);
  assign push.v1 = advance & ea & eb;
  assign push.r0 = ea ? res_a : res_b;
  assign push.r1 = res_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      vld_r       <= '0;
      last_data_r <= 2'd0;
      for (int s = 0; s < 3; s++) begin
        cnt_r[s] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (we) begin
        vld_r[s1_addr] <= 1'b1;
      end
      if (advance && data_ok) begin
        last_data_r <= val;
        for (int s = 0; s < 3; s++) begin
          cnt_r[s] <= cnt_nxt[s];
        end
      end
    end
  end

  // ram read and write at the same edge return the old entry, so forward it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_item;
      byp_hit_r  <= we && (s1_addr == raddr);
      byp_data_r <= val;
    end
  end

endmodule

[rtl/qrdm_out_fifo.sv]
`timescale 1ns / 1ps
// result queue taking up to two words a cycle and giving one
module qrdm_out_fifo import qrdm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, tail_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[head_r];
  assign pop       = out_valid & out_ready;
  assign room      = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[tail_r] <= push.r0;
    end
    if (push.v1) begin
      mem[tail_r + FIFO_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (pop) begin
        head_r <= head_r + FIFO_AW'(1);
      end
      tail_r <= tail_r + FIFO_AW'(push.v0) + FIFO_AW'(push.v1);
      cnt_r  <= cnt_r + FIFO_CW'(push.v0) + FIFO_CW'(push.v1) - FIFO_CW'(pop);
    end
  end

endmodule

[rtl/qutrit_repetition_defect_majority.sv]
`timescale 1ns / 1ps
// top level: qutrit repetition code defect extraction and majority decode
//
// input stream: one measurement word per transfer; in_tuser says syndrome (0) or
// final data qutrit (1). output stream: defect, boundary and decision words, with
// out_tuser giving the kind and out_tlast marking the final word caused by one input.
// configuration goes through the apb port; write only while the block is idle.
//
// an accepted word waits in the input register and its results are written to the
// output queue once the queue has room; the queue's head word drives out_t* directly.
// one input word per cycle while each input yields at most one result and the
// receiver is ready; a two-result input (boundary check plus decision) uses two
// output transfers. the rate is set by the single output port of the result queue.
// the syndrome store is a ram with registered read, addressed at acceptance.
//
// reset clears the syndrome valid bits, counts, queue and registers to their
// defaults. when the receiver stalls, the four-word queue fills and in_tready
// drops once fewer than two free slots remain; nothing is lost.
module qutrit_repetition_defect_majority import qrdm_pkg::*; #(
  parameter int MAX_DISTANCE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // position, round_number, raw_value
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // round_label, edge_index, syndrome_value,
                                  // previous_value, defect_value, decision, tie,
                                  // failure, zero fill
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t    cfg;
  item_t   item;
  push_t   push;
  logic    room;
  result_t res;

  assign item.cmd          = in_tuser;
  assign item.position     = in_tdata[5:0];
  assign item.round_number = in_tdata[15:6];
  assign item.raw_value    = in_tdata[23:16];

  qrdm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  qrdm_core #(
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (item),
    .room     (room),
    .push     (push)
  );

  qrdm_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'd0, res.failure, res.tie, res.decision, res.defect_value,
                      res.previous_value, res.syndrome_value, res.edge_index,
                      res.round_label};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the qutrit repetition defect and majority decode block
module tb_top;
  import qrdm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // position, round_number, raw_value
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // round_label, edge_index, syndrome_value, previous_value,
                                // defect_value, decision, tie, failure, zero fill
  logic [1:0]  out_tuser;       // kind
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of registers and state
  logic [6:0]  cfg_dist = 7'd3;
  logic [9:0]  cfg_rounds = 10'd5;
  logic        cfg_emit = 1'b0;
  logic [1:0]  cfg_expect = 2'd0;
  logic [1:0]  syn_hist [0:62] = '{default: 2'd0};
  logic [1:0]  last_trit = 2'd0;
  logic [6:0]  trit_count [0:2] = '{default: 7'd0};

  result_t     due_records [$];
  result_t     got, want;
  int          errors = 0;
  int          live_items = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  bit          hold_req = 1'b0;
  int          stall_left = 0;

  qutrit_repetition_defect_majority DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [1:0] trit_of(input logic [7:0] raw);
    int v;
    v = int'(raw);
    return (v >= 128) ? 2'((v + 2) % 3) : 2'(v % 3);
  endfunction

  function automatic logic [1:0] mod3_diff(input logic [1:0] a, input logic [1:0] b);
    return 2'((int'(a) + 3 - int'(b)) % 3);
  endfunction

  function automatic int eff_distance();
    int d;
    d = int'(cfg_dist);
    if (d < 2) d = 2;
    if (d > 64) d = 64;
    return d;
  endfunction

  task automatic add_due(input result_t rec);
    due_records.insert(due_records.size(), rec);
  endtask

  // expected records for one accepted word
  task automatic decode_word(input logic cmd, input logic [5:0] pos, input logic [9:0] rnd,
                             input logic [7:0] raw);
    int span, best, best_n, s, nrec;
    logic [1:0] trit, prev, chk, dft;
    bit tied, seen;
    result_t rec;
    result_t recs [2];
    span = eff_distance();
    trit = trit_of(raw);
    rec = '0;
    nrec = 0;
    if (cmd == CMD_SYNDROME) begin
      if (pos < span - 1 && pos < 63) begin
        live_items++;
        prev = (rnd == 10'd0) ? 2'd0 : syn_hist[pos];
        dft = mod3_diff(trit, prev);
        syn_hist[pos] = trit;
        if (cfg_emit || dft != 2'd0) begin
          rec.kind = KIND_ROUND;
          rec.round_label = rnd;
          rec.edge_index = pos;
          rec.syndrome_value = trit;
          rec.previous_value = prev;
          rec.defect_value = dft;
          recs[nrec] = rec;
          nrec++;
        end
      end
    end else if (pos < span) begin
      live_items++;
      if (pos == 6'd0) begin
        trit_count = '{default: 7'd0};
      end else begin
        chk = mod3_diff(last_trit, trit);
        prev = syn_hist[pos - 1];
        dft = mod3_diff(chk, prev);
        if (cfg_emit || dft != 2'd0) begin
          rec.kind = KIND_BOUNDARY;
          rec.round_label = cfg_rounds;
          rec.edge_index = pos - 6'd1;
          rec.syndrome_value = chk;
          rec.previous_value = prev;
          rec.defect_value = dft;
          recs[nrec] = rec;
          nrec++;
        end
      end
      last_trit = trit;
      if (trit_count[trit] < COUNT_MAX) trit_count[trit]++;
      if (pos == span - 1) begin
        best = 0;
        best_n = 0;
        tied = 1'b0;
        seen = 1'b0;
        for (s = 0; s < 3; s++) begin
          if (!seen || int'(trit_count[s]) > best_n) begin
            best = s;
            best_n = int'(trit_count[s]);
            tied = 1'b0;
            seen = 1'b1;
          end else if (int'(trit_count[s]) == best_n) begin
            tied = 1'b1;
          end
        end
        rec = '0;
        rec.kind = KIND_DECISION;
        rec.round_label = cfg_rounds;
        rec.decision = tied ? 2'd0 : 2'(best);
        rec.tie = tied;
        rec.failure = tied || (rec.decision != cfg_expect);
        recs[nrec] = rec;
        nrec++;
      end
    end
    if (nrec > 0) recs[nrec - 1].last = 1'b1;
    for (s = 0; s < nrec; s++) add_due(recs[s]);
  endtask

  task automatic send_word(input logic cmd, input logic [5:0] pos, input logic [9:0] rnd,
                           input logic [7:0] raw);
    in_tvalid <= 1'b1;
    in_tdata <= {raw, rnd, pos};
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_word(cmd, pos, rnd, raw);
    if (!src_steady && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  endtask

  task automatic send_noise();
    send_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
              10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_DISTANCE: begin
        cfg_dist = val[6:0];
        readback = {25'd0, val[6:0]};
      end
      REG_ROUNDS: begin
        cfg_rounds = val[9:0];
        readback = {22'd0, val[9:0]};
      end
      REG_EMIT_ALL: begin
        cfg_emit = val[0];
        readback = {31'd0, val[0]};
      end
      default: begin
        cfg_expect = val[1:0];
        readback = {30'd0, val[1:0]};
      end
    endcase
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== readback) begin
      $display("%0t: register %s read expected %0h got %0h", $time, idx.name(),
               readback, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // receiver with random stalls and an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
      stall_left = pause_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cmp_field(input string name, input logic [9:0] e, input logic [9:0] g);
    if (e !== g) begin
      $display("%0t: %s expected %0d got %0d", $time, name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.round_label = out_tdata[9:0];
      got.edge_index = out_tdata[15:10];
      got.syndrome_value = out_tdata[17:16];
      got.previous_value = out_tdata[19:18];
      got.defect_value = out_tdata[21:20];
      got.decision = out_tdata[23:22];
      got.tie = out_tdata[24];
      got.failure = out_tdata[25];
      got.last = out_tlast;
      if (due_records.size() == 0) begin
        $display("%0t: unexpected word expected none got %h kind %0d", $time, out_tdata,
                 out_tuser);
        errors++;
      end else begin
        want = due_records.pop_front();
        cmp_field("kind", 10'(want.kind), 10'(got.kind));
        cmp_field("round_label", want.round_label, got.round_label);
        cmp_field("edge_index", 10'(want.edge_index), 10'(got.edge_index));
        cmp_field("syndrome_value", 10'(want.syndrome_value), 10'(got.syndrome_value));
        cmp_field("previous_value", 10'(want.previous_value), 10'(got.previous_value));
        cmp_field("defect_value", 10'(want.defect_value), 10'(got.defect_value));
        cmp_field("decision", 10'(want.decision), 10'(got.decision));
        cmp_field("tie", 10'(want.tie), 10'(got.tie));
        cmp_field("failure", 10'(want.failure), 10'(got.failure));
        cmp_field("last", 10'(want.last), 10'(got.last));
      end
    end
  end

  task automatic test_directed_cases();
    write_reg(REG_EMIT_ALL, 32'd1);
    send_word(CMD_SYNDROME, 6'd0, 10'd0, 8'd0);
    send_word(CMD_SYNDROME, 6'd0, 10'd1, 8'd127);
    send_word(CMD_SYNDROME, 6'd1, 10'd1023, 8'h80);
    send_word(CMD_SYNDROME, 6'd1, 10'd0, 8'hFF);
    // out of range edges and qutrit
    send_word(CMD_SYNDROME, 6'd2, 10'd1, 8'd5);
    send_word(CMD_SYNDROME, 6'd63, 10'd1, 8'd5);
    send_word(CMD_DATA, 6'd3, 10'd0, 8'd1);
    // one of each symbol gives a tie
    send_word(CMD_DATA, 6'd0, 10'd0, 8'd0);
    send_word(CMD_DATA, 6'd1, 10'd0, 8'd1);
    send_word(CMD_DATA, 6'd2, 10'd0, 8'd2);
    wait_idle();
    write_reg(REG_EXPECTED, 32'd3);
    send_word(CMD_DATA, 6'd0, 10'd0, 8'd1);
    send_word(CMD_DATA, 6'd1, 10'd0, 8'd4);
    send_word(CMD_DATA, 6'd2, 10'd0, 8'd7);
    // last qutrit without its neighbour before it
    send_word(CMD_DATA, 6'd2, 10'd0, 8'hFE);
    wait_idle();
    write_reg(REG_EMIT_ALL, 32'd0);
    write_reg(REG_EXPECTED, 32'd1);
    send_word(CMD_DATA, 6'd0, 10'd0, 8'd3);
    send_word(CMD_DATA, 6'd1, 10'd0, 8'd3);
    send_word(CMD_DATA, 6'd2, 10'd0, 8'd1);
  endtask

  task automatic test_distance_extremes();
    wait_idle();
    write_reg(REG_DISTANCE, 32'd0);
    write_reg(REG_ROUNDS, 32'd0);
    write_reg(REG_EMIT_ALL, 32'd1);
    write_reg(REG_EXPECTED, 32'd2);
    send_word(CMD_SYNDROME, 6'd0, 10'd7, 8'd2);
    send_word(CMD_SYNDROME, 6'd1, 10'd7, 8'd2);
    send_word(CMD_DATA, 6'd0, 10'd0, 8'd2);
    send_word(CMD_DATA, 6'd1, 10'd0, 8'hFB);
    wait_idle();
    write_reg(REG_DISTANCE, 32'd127);
    write_reg(REG_ROUNDS, 32'd1023);
    send_word(CMD_SYNDROME, 6'd62, 10'd1, 8'd1);
    send_word(CMD_SYNDROME, 6'd63, 10'd1, 8'd1);
    send_word(CMD_DATA, 6'd63, 10'd0, 8'd5);
    wait_idle();
    write_reg(REG_DISTANCE, 32'd1);
    send_word(CMD_DATA, 6'd1, 10'd0, 8'd0);
  endtask

  // counts saturate after many qutrits with no restart
  task automatic test_count_saturation();
    int i;
    wait_idle();
    write_reg(REG_DISTANCE, 32'd64);
    write_reg(REG_EMIT_ALL, 32'd0);
    write_reg(REG_EXPECTED, 32'd0);
    send_word(CMD_DATA, 6'd0, 10'd0, 8'd0);
    for (i = 0; i < 140; i++) begin
      send_word(CMD_DATA, 6'(1 + i % 62), 10'd0, 8'd3);
    end
    send_word(CMD_DATA, 6'd63, 10'd0, 8'd1);
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    write_reg(REG_DISTANCE, 32'd2);
    write_reg(REG_EMIT_ALL, 32'd1);
    src_steady = 1'b1;
    hold_req = 1'b1;
    for (i = 0; i < 80; i++) begin
      send_word(CMD_DATA, 6'(i % 2), 10'd0, 8'($urandom_range(0, 255)));
    end
    src_steady = 1'b0;
  endtask

  function automatic logic [7:0] encoded_raw(input int sym);
    int k;
    k = int'($urandom_range(0, 83)) - 42;
    return 8'(3 * k + sym);
  endfunction

  task automatic run_shot(input int d);
    int rounds, r, e, q, sym, base;
    logic [7:0] raw;
    rounds = $urandom_range(1, 4);
    base = $urandom_range(0, 1019);
    for (r = 0; r < rounds; r++) begin
      for (e = 0; e < d - 1; e++) begin
        raw = ($urandom_range(0, 99) < 30) ? encoded_raw(0) : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 6) send_noise();
        else send_word(CMD_SYNDROME, 6'(e), 10'((r == 0) ? 0 : base + r), raw);
      end
    end
    sym = $urandom_range(0, 2);
    for (q = 0; q < d; q++) begin
      if ($urandom_range(0, 99) < 4) continue;
      raw = ($urandom_range(0, 99) < 20) ? 8'($urandom_range(0, 255)) : encoded_raw(sym);
      send_word(CMD_DATA, 6'(q), 10'($urandom_range(0, 1023)), raw);
    end
  endtask

  task automatic test_random_shots();
    int goal, n, r, d;
    goal = live_items + 1300;
    while (live_items < goal) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 65) d = $urandom_range(2, 6);
      else if (r < 85) d = $urandom_range(7, 16);
      else if (r < 93) d = $urandom_range(17, 63);
      else begin
        case ($urandom_range(0, 4))
          0: d = 0;
          1: d = 1;
          2: d = 64;
          3: d = 65;
          default: d = 127;
        endcase
      end
      write_reg(REG_DISTANCE, 32'(d));
      r = $urandom_range(0, 99);
      write_reg(REG_ROUNDS, (r < 10) ? 32'd0 : (r < 20) ? 32'd1023 : 32'($urandom_range(1, 1022)));
      write_reg(REG_EMIT_ALL, 32'($urandom_range(0, 1)));
      write_reg(REG_EXPECTED, 32'($urandom_range(0, 3)));
      src_steady = ($urandom_range(0, 99) < 20);
      sink_steady = ($urandom_range(0, 99) < 20);
      for (n = 0; n < 3; n++) run_shot(eff_distance());
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_distance_extremes();
    test_count_saturation();
    test_backpressure();
    test_random_shots();
    wait_idle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
